### design/pqmf_pkg.sv
// ----------------------------------------------------------------------------
// PQMF synthesis package
// Shared sizes, item types, back-end states and the synthesis tap table.
// ----------------------------------------------------------------------------
package pqmf_pkg;

  localparam int SUBBANDS       = 4;
  localparam int FILTER_TAPS    = 63;
  localparam int HISTORY_FRAMES = 16;
  localparam int MAX_RESULTS    = 34;
  localparam int CENTER         = (FILTER_TAPS - 1) / 2;
  localparam int SEEN_MAX       = 15;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int ACC_W     = PROD_W + $clog2(SUBBANDS) + $clog2(SUBBANDS * HISTORY_FRAMES) + 1;
  localparam int OUT_FRAC  = 15;
  localparam int Y_W       = ACC_W - OUT_FRAC;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int ROUND_HALF = 16384;

  localparam int SLOT_W    = $clog2(HISTORY_FRAMES);
  localparam int SEEN_W    = $clog2(SEEN_MAX + 1);
  localparam int BAND_W    = $clog2(SUBBANDS);
  localparam int TAPIDX_W  = $clog2(FILTER_TAPS);
  localparam int SPAN_W    = TAPIDX_W + 1;
  localparam int E_RAW_W   = $clog2(CENTER + SUBBANDS * SEEN_MAX + 1);
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int ROM_IDX_W = $clog2(SUBBANDS * FILTER_TAPS);

  localparam int JOB_DEPTH  = 2;
  localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);
  localparam int RES_DEPTH  = 2;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [SUBBANDS-1:0] frame_t;

  typedef struct packed {
    frame_t                samples;
    logic                  final_frame;
    logic [SLOT_W-1:0]     slot;
    logic [TAPIDX_W-1:0]   e_start;
    logic [CNT_W-1:0]      count;
  } job_t;

  typedef struct packed {
    sample_t audio_sample;
    logic    clipped;
    logic    stream_end;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT
  } back_state_e;

  typedef logic [SUBBANDS*FILTER_TAPS*TAP_W-1:0] tap_rom_t;

  // Half of the symmetric prototype, units of 2^-24.
  function automatic int proto_half(input int m);
    case (m)
      0:  return 140;
      1:  return 450;
      2:  return 848;
      3:  return 1029;
      4:  return 462;
      5:  return -1448;
      6:  return -5021;
      7:  return -9872;
      8:  return -14547;
      9:  return -16490;
      10: return -12536;
      11: return 0;
      12: return 21811;
      13: return 50130;
      14: return 77948;
      15: return 94538;
      16: return 87675;
      17: return 47395;
      18: return -29469;
      19: return -135237;
      20: return -249347;
      21: return -339579;
      22: return -367053;
      23: return -294461;
      24: return -95878;
      25: return 234298;
      26: return 675868;
      27: return 1182830;
      28: return 1689573;
      29: return 2122374;
      30: return 2413789;
      31: return 2516582;
      default: return 0;
    endcase
  endfunction

  // Quarter wave of cos(j*pi/32), units of 2^-16.
  function automatic int cos_quarter(input int j);
    case (j)
      0:  return 65536;
      1:  return 65220;
      2:  return 64277;
      3:  return 62714;
      4:  return 60547;
      5:  return 57798;
      6:  return 54491;
      7:  return 50660;
      8:  return 46341;
      9:  return 41576;
      10: return 36410;
      11: return 30893;
      12: return 25080;
      13: return 19024;
      14: return 12785;
      15: return 6424;
      default: return 0;
    endcase
  endfunction

  function automatic int proto_at(input int n);
    int m;
    m = n - CENTER + 31;
    if (m < 0 || m > 62) begin
      return 0;
    end
    if (m > 31) begin
      m = 62 - m;
    end
    return proto_half(m);
  endfunction

  function automatic int cos_at(input int q_in);
    int q;
    q = q_in & 63;
    if (q <= 16) begin
      return cos_quarter(q);
    end
    if (q <= 32) begin
      return -cos_quarter(32 - q);
    end
    if (q <= 48) begin
      return -cos_quarter(q - 32);
    end
    return cos_quarter(64 - q);
  endfunction

  // Tap table, signed Q0.16, evaluated at elaboration.
  function automatic tap_rom_t build_tap_rom();
    tap_rom_t rom;
    int       k;
    int       n;
    int       sgn;
    int       ph;
    int       pm;
    int       q;
    longint   prod;
    longint   mag;
    longint   rnd;
    rom = '0;
    for (k = 0; k < SUBBANDS; k++) begin
      for (n = 0; n < FILTER_TAPS; n++) begin
        sgn  = ((k & 1) != 0) ? -1 : 1;
        ph   = 2 * (2 * k + 1) * (n - CENTER) - sgn * SUBBANDS;
        pm   = ((ph % (8 * SUBBANDS)) + 8 * SUBBANDS) % (8 * SUBBANDS);
        q    = (pm * 8 + SUBBANDS / 2) / SUBBANDS;
        prod = longint'(proto_at(n)) * longint'(cos_at(q));
        mag  = (prod < 0) ? -prod : prod;
        rnd  = (mag + (longint'(1) <<< 23)) >>> 24;
        if (prod < 0) begin
          rnd = -rnd;
        end
        rom[(k * FILTER_TAPS + n) * TAP_W +: TAP_W] = TAP_W'(rnd);
      end
    end
    return rom;
  endfunction

  localparam tap_rom_t TAP_ROM = build_tap_rom();

endpackage

### design/pqmf_front.sv
// ----------------------------------------------------------------------------
// PQMF front end
// Accepts frames, assigns history slots and works out which outputs each
// frame releases.
// ----------------------------------------------------------------------------
module pqmf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pqmf_pkg::frame_t frame_i,
  input  logic             final_frame_i,
  input  logic             job_full_i,
  output logic             full_o,
  output logic             job_push_o,
  output pqmf_pkg::job_t   job_o
);
  import pqmf_pkg::*;

  logic [SLOT_W-1:0]   write_slot_q, write_slot_d;
  logic [SEEN_W-1:0]   frames_seen_q, frames_seen_d;
  logic [E_RAW_W-1:0]  e_raw;
  logic [TAPIDX_W-1:0] e_first;
  logic [TAPIDX_W-1:0] e_last;
  logic [SPAN_W-1:0]   span;
  logic [CNT_W-1:0]    n_out;

  assign full_o     = job_full_i;
  assign job_push_o = push_i && !job_full_i;

  // Outputs run from the newest position the history reaches down to the
  // end of this frame, or to the end of the zero tail on the last frame.
  always_comb begin
    e_raw   = E_RAW_W'(CENTER) + E_RAW_W'(SUBBANDS) * E_RAW_W'(frames_seen_q);
    e_first = (e_raw > E_RAW_W'(2 * CENTER)) ? TAPIDX_W'(2 * CENTER)
                                             : e_raw[TAPIDX_W-1:0];
    e_last  = final_frame_i ? TAPIDX_W'(CENTER - SUBBANDS + 1)
                            : TAPIDX_W'(2 * CENTER - SUBBANDS + 1);
    if (e_first >= e_last) begin
      span = {1'b0, e_first} - {1'b0, e_last} + SPAN_W'(1);
    end else begin
      span = '0;
    end
    n_out = (span > SPAN_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(span);
  end

  always_comb begin
    job_o.samples     = frame_i;
    job_o.final_frame = final_frame_i;
    job_o.slot        = write_slot_q;
    job_o.e_start     = e_first;
    job_o.count       = n_out;
  end

  always_comb begin
    write_slot_d  = write_slot_q;
    frames_seen_d = frames_seen_q;
    if (job_push_o) begin
      if (final_frame_i) begin
        write_slot_d  = '0;
        frames_seen_d = '0;
      end else begin
        write_slot_d  = (write_slot_q == SLOT_W'(HISTORY_FRAMES - 1)) ? '0
                                                                      : write_slot_q + 1'b1;
        frames_seen_d = (frames_seen_q == SEEN_W'(SEEN_MAX)) ? frames_seen_q
                                                              : frames_seen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q  <= '0;
      frames_seen_q <= '0;
    end else begin
      write_slot_q  <= write_slot_d;
      frames_seen_q <= frames_seen_d;
    end
  end

endmodule

### design/pqmf_job_queue.sv
// ----------------------------------------------------------------------------
// PQMF job queue
// Short queue of classified frames between the front and back ends.
// ----------------------------------------------------------------------------
module pqmf_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pqmf_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output pqmf_pkg::job_t data_o
);
  import pqmf_pkg::*;

  job_t                 slots_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [JOB_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [JOB_CNT_W-1:0] fill_q, fill_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (fill_q == JOB_CNT_W'(JOB_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/pqmf_back.sv
// ----------------------------------------------------------------------------
// PQMF back end
// Holds the frame history and runs one multiply-accumulate per cycle, while in
// its MAC state, over history rows and bands for each output sample.
// ----------------------------------------------------------------------------
module pqmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  pqmf_pkg::job_t    job_i,
  output logic              job_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output pqmf_pkg::result_t res_o
);
  import pqmf_pkg::*;

  back_state_e state_q, state_d;

  frame_t hist_mem [HISTORY_FRAMES];
  logic                      mem_we;
  logic                      rd_en;
  logic [SLOT_W-1:0]         rd_addr;
  frame_t                    row_q;
  logic                      row_ok_q;

  logic [HISTORY_FRAMES-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic                      fin_q, fin_d;
  logic [TAPIDX_W-1:0]       e_q, e_d;
  logic [CNT_W-1:0]          left_q, left_d;
  logic [TAPIDX_W-1:0]       j_q, j_d;
  logic [SLOT_W-1:0]         rd_slot_q, rd_slot_d;
  logic [SLOT_W-1:0]         r_q, r_d;
  logic [BAND_W-1:0]         k_q, k_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic                      prod_ok_q, prod_ok_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  logic [ROM_IDX_W-1:0]      tap_idx;
  logic signed [TAP_W-1:0]   tap_val;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [Y_W-1:0]     y;

  assign tap_idx = ROM_IDX_W'(int'(k_q) * FILTER_TAPS + int'(j_q));
  assign tap_val = $signed(TAP_ROM[int'(tap_idx) * TAP_W +: TAP_W]);

  // Round half up, then saturate.
  always_comb begin
    rnd = acc_q + ACC_W'(ROUND_HALF);
    y   = $signed(rnd[ACC_W-1:OUT_FRAC]);
    res_o.stream_end = fin_q && (left_q == CNT_W'(1));
    if (y > Y_W'(SAMPLE_MAX)) begin
      res_o.audio_sample = SAMPLE_W'(SAMPLE_MAX);
      res_o.clipped      = 1'b1;
    end else if (y < Y_W'(SAMPLE_MIN)) begin
      res_o.audio_sample = SAMPLE_W'(SAMPLE_MIN);
      res_o.clipped      = 1'b1;
    end else begin
      res_o.audio_sample = y[SAMPLE_W-1:0];
      res_o.clipped      = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rd_slot_q;
    valid_d    = valid_q;
    slot_d     = slot_q;
    fin_d      = fin_q;
    e_d        = e_q;
    left_d     = left_q;
    j_d        = j_q;
    rd_slot_d  = rd_slot_q;
    r_d        = r_q;
    k_d        = k_q;
    prod_d     = prod_q;
    prod_ok_d  = 1'b0;
    acc_d      = prod_ok_q ? acc_q + ACC_W'(prod_q) * ACC_W'(SUBBANDS) : acc_q;

    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          mem_we    = 1'b1;
          slot_d    = job_i.slot;
          fin_d     = job_i.final_frame;
          e_d       = job_i.e_start;
          left_d    = job_i.count;
          if (job_i.count == '0) begin
            valid_d = job_i.final_frame ? '0 : (valid_q | (HISTORY_FRAMES'(1) << job_i.slot));
          end else begin
            valid_d[job_i.slot] = 1'b1;
            state_d = BK_LOAD;
          end
        end
      end
      BK_LOAD: begin
        // Start a new output at the newest frame.
        rd_en     = 1'b1;
        rd_addr   = slot_q;
        rd_slot_d = slot_q;
        j_d       = e_q;
        r_d       = '0;
        k_d       = '0;
        acc_d     = '0;
        state_d   = BK_MAC;
      end
      BK_MAC: begin
        if (row_ok_q) begin
          prod_d = tap_val * $signed(row_q[k_q]);
        end else begin
          prod_d = '0;
        end
        prod_ok_d = 1'b1;
        if (k_q == BAND_W'(SUBBANDS - 1)) begin
          k_d = '0;
          if (j_q >= TAPIDX_W'(SUBBANDS) && r_q != SLOT_W'(HISTORY_FRAMES - 1)) begin
            // Fetch the next older frame while the last band finishes.
            rd_en     = 1'b1;
            rd_addr   = (rd_slot_q == '0) ? SLOT_W'(HISTORY_FRAMES - 1) : rd_slot_q - 1'b1;
            rd_slot_d = rd_addr;
            j_d       = j_q - TAPIDX_W'(SUBBANDS);
            r_d       = r_q + 1'b1;
          end else begin
            state_d = BK_DRAIN;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      BK_DRAIN: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          left_d     = left_q - 1'b1;
          e_d        = e_q - 1'b1;
          if (left_q == CNT_W'(1)) begin
            if (fin_q) begin
              valid_d = '0;
            end
            state_d = BK_IDLE;
          end else begin
            state_d = BK_LOAD;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      prod_ok_q <= 1'b0;
      left_q    <= '0;
      fin_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      prod_ok_q <= prod_ok_d;
      left_q    <= left_d;
      fin_q     <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    e_q       <= e_d;
    j_q       <= j_d;
    rd_slot_q <= rd_slot_d;
    r_q       <= r_d;
    k_q       <= k_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
  end

  // History memory: one row write, one registered row read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[job_i.slot] <= job_i.samples;
    end
    if (rd_en) begin
      row_q    <= hist_mem[rd_addr];
      row_ok_q <= valid_q[rd_addr];
    end
  end

`ifndef NO_ASSERTIONS
  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MAC) |-> (j_q <= TAPIDX_W'(2 * CENTER)))
    else $error("tap index beyond filter length");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && fin_q && (left_q == CNT_W'(1))) |=> (valid_q == '0))
    else $error("history not cleared after stream end");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_pop_o && !job_i.final_frame) |=> valid_q[slot_q])
    else $error("new frame row not marked valid");

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> (left_q != '0))
    else $error("back end busy with no outputs left");
`endif

endmodule

### design/pqmf_result_queue.sv
// ----------------------------------------------------------------------------
// PQMF result queue
// Output buffer that lets the back end run on while a word waits.
// ----------------------------------------------------------------------------
module pqmf_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pqmf_pkg::result_t data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output pqmf_pkg::result_t data_o
);
  import pqmf_pkg::*;

  result_t              slots_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] fill_q, fill_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (fill_q == RES_CNT_W'(RES_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/pqmf_synthesis_filterbank_unit.sv
// ----------------------------------------------------------------------------
// PQMF synthesis filterbank, four bands
// A single multiply-accumulate sets the pace, working band by band over each
// history row, up to 16 rows per output; a regular frame releases up to
// 4 outputs and a final frame flushes up to 34. Frames wait in the job
// queue while the back end is busy.
// Reset clears the history valid bits, slot and frame counters at once.
// ----------------------------------------------------------------------------
module pqmf_synthesis_filterbank_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   band0_sample_i,
  input  logic signed [15:0]   band1_sample_i,
  input  logic signed [15:0]   band2_sample_i,
  input  logic signed [15:0]   band3_sample_i,
  input  logic                 final_frame_i,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [15:0]   audio_sample_o,
  output logic                 clipped_o,
  output logic                 stream_end_o
);
  import pqmf_pkg::*;

  frame_t  frame;
  job_t    front_job;
  job_t    back_job;
  logic    job_push;
  logic    job_pop;
  logic    job_full;
  logic    job_empty;
  result_t back_res;
  result_t out_res;
  logic    res_push;
  logic    res_full;

  always_comb begin
    frame[0] = band0_sample_i;
    frame[1] = band1_sample_i;
    frame[2] = band2_sample_i;
    frame[3] = band3_sample_i;
  end

  pqmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .frame_i      (frame),
    .final_frame_i(final_frame_i),
    .job_full_i   (job_full),
    .full_o       (full),
    .job_push_o   (job_push),
    .job_o        (front_job)
  );

  pqmf_job_queue u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (front_job),
    .pop_i  (job_pop),
    .full_o (job_full),
    .empty_o(job_empty),
    .data_o (back_job)
  );

  pqmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (back_job),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  pqmf_result_queue u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .pop_i  (pop),
    .full_o (res_full),
    .empty_o(empty),
    .data_o (out_res)
  );

  assign audio_sample_o = out_res.audio_sample;
  assign clipped_o      = out_res.clipped;
  assign stream_end_o   = out_res.stream_end;

endmodule

### tb/sv/tb_pqmf_synthesis_filterbank_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-band PQMF synthesis filterbank testbench
// Feeds subband frames in streams that close with a final frame. A directed
// table covers full-scale and single-band frames, stream start, saturation
// and the capped flush. Random streams follow. Input and output sides idle at
// random, and the output side holds off once long enough to back up the
// input. Words are checked against a local synthesis model or typed zeros.
// ----------------------------------------------------------------------------
module tb_pqmf_synthesis_filterbank_unit;
  import pqmf_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int ITEMS       = 270;
  localparam int HOLD_AFTER  = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 400;
  localparam int TIMEOUT_NS  = 80_000_000;

  localparam sample_t POS_FS = 16'sh7FFF;
  localparam sample_t NEG_FS = 16'sh8000;
  localparam sample_t ZERO_S = 16'sh0000;

  typedef struct packed {
    sample_t    b0;
    sample_t    b1;
    sample_t    b2;
    sample_t    b3;
    logic       fin;
    logic       typed;  // expected words typed in: n_typed zero words
    logic [5:0] n_typed;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  sample_t band0_sample_i = '0;
  sample_t band1_sample_i = '0;
  sample_t band2_sample_i = '0;
  sample_t band3_sample_i = '0;
  logic final_frame_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  sample_t audio_sample_o;
  logic clipped_o;
  logic stream_end_o;

  pqmf_synthesis_filterbank_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .band0_sample_i (band0_sample_i),
    .band1_sample_i (band1_sample_i),
    .band2_sample_i (band2_sample_i),
    .band3_sample_i (band3_sample_i),
    .final_frame_i  (final_frame_i),
    .empty          (empty),
    .pop            (pop),
    .audio_sample_o (audio_sample_o),
    .clipped_o      (clipped_o),
    .stream_end_o   (stream_end_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Prototype half in units of 2^-24, cosine quarter wave in units of 2^-16.
  int proto_q24 [32] = '{
    140, 450, 848, 1029, 462, -1448, -5021, -9872,
    -14547, -16490, -12536, 0, 21811, 50130, 77948, 94538,
    87675, 47395, -29469, -135237, -249347, -339579, -367053, -294461,
    -95878, 234298, 675868, 1182830, 1689573, 2122374, 2413789, 2516582
  };
  int cos_q16 [17] = '{
    65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660,
    46341, 41576, 36410, 30893, 25080, 19024, 12785, 6424, 0
  };

  int          synth_taps [SUBBANDS][FILTER_TAPS];
  sample_t     hist [HISTORY_FRAMES][SUBBANDS];
  int          next_slot;
  int          frames_in_stream;
  result_t     expected_words [$];
  frame_row_t  dir_rows [23];

  int mismatches;
  int words_checked;
  int words_clipped;
  int stream_ends;
  int frames_sent;
  int streams_sent;
  int full_cycles;
  int tx_calm;
  int rx_calm;
  bit hold_done;

  function automatic void build_synth_taps();
    int     k;
    int     n;
    int     m;
    int     ph;
    int     q;
    int     pr;
    int     cs;
    longint prod;
    longint mag;
    longint rnd;
    for (k = 0; k < SUBBANDS; k++) begin
      for (n = 0; n < FILTER_TAPS; n++) begin
        // odd bands take +pi/4, even bands -pi/4
        ph = 2 * (2 * k + 1) * (n - CENTER) + (((k % 2) != 0) ? SUBBANDS : -SUBBANDS);
        ph = ph % (8 * SUBBANDS);
        if (ph < 0) begin
          ph += 8 * SUBBANDS;
        end
        q = ((ph * 8 + SUBBANDS / 2) / SUBBANDS) & 63;
        if (q > 32) begin
          q = 64 - q;
        end
        cs = (q > 16) ? -cos_q16[32 - q] : cos_q16[q];
        m = n - CENTER + 31;
        pr = (m < 0 || m > 62) ? 0 : proto_q24[(m > 31) ? 62 - m : m];
        prod = longint'(pr) * longint'(cs);
        mag = (prod < 0) ? -prod : prod;
        rnd = (mag + (longint'(1) <<< 23)) >>> 24;
        synth_taps[k][n] = int'((prod < 0) ? -rnd : rnd);
      end
    end
  endfunction

  function automatic void clear_history();
    foreach (hist[s, k]) begin
      hist[s][k] = '0;
    end
    next_slot = 0;
    frames_in_stream = 0;
  endfunction

  // One output sample at offset d from the start of the current frame.
  function automatic result_t synth_output(int cur, int d);
    longint  acc;
    longint  y;
    int      r;
    int      j;
    int      k;
    result_t w;
    acc = 0;
    for (r = 0; r < HISTORY_FRAMES; r++) begin
      j = CENTER - d - SUBBANDS * r;
      if (j < 0) begin
        break;
      end
      if (j <= 2 * CENTER) begin
        for (k = 0; k < SUBBANDS; k++) begin
          acc += longint'(synth_taps[k][j]) * SUBBANDS *
                 longint'(hist[(cur + HISTORY_FRAMES - r) % HISTORY_FRAMES][k]);
        end
      end
    end
    y = (acc + ROUND_HALF) >>> OUT_FRAC;
    w.clipped = 1'b0;
    w.stream_end = 1'b0;
    if (y > SAMPLE_MAX) begin
      y = SAMPLE_MAX;
      w.clipped = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y = SAMPLE_MIN;
      w.clipped = 1'b1;
    end
    w.audio_sample = sample_t'(y);
    return w;
  endfunction

  // Advance the model by one frame; queue the words it releases when keep is set.
  function automatic void synth_frame(frame_row_t row, bit keep);
    result_t words [$];
    result_t w;
    int      cur;
    int      d;
    int      dhi;
    cur = next_slot;
    hist[cur][0] = row.b0;
    hist[cur][1] = row.b1;
    hist[cur][2] = row.b2;
    hist[cur][3] = row.b3;
    dhi = row.fin ? SUBBANDS - 1 : SUBBANDS - 1 - CENTER;
    for (d = -CENTER; d <= dhi; d++) begin
      if (SUBBANDS * frames_in_stream + d < 0) begin
        continue;
      end
      // flush is capped, the tail of a long stream is dropped
      if (words.size() >= MAX_RESULTS) begin
        break;
      end
      words.push_back(synth_output(cur, d));
    end
    if (row.fin) begin
      if (words.size() > 0) begin
        w = words.pop_back();
        w.stream_end = 1'b1;
        words.push_back(w);
      end
      clear_history();
    end else begin
      next_slot = (cur + 1) % HISTORY_FRAMES;
      if (frames_in_stream < SEEN_MAX) begin
        frames_in_stream++;
      end
    end
    if (keep) begin
      foreach (words[i]) begin
        expected_words.push_back(words[i]);
      end
    end
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(80, 20);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return POS_FS;
      1: return NEG_FS;
      2: return ZERO_S;
      3, 4: return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_frame(frame_row_t row);
    int gap;
    result_t w;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    band0_sample_i <= row.b0;
    band1_sample_i <= row.b1;
    band2_sample_i <= row.b2;
    band3_sample_i <= row.b3;
    final_frame_i <= row.fin;
    @(posedge clk_i);
    while (full) begin
      full_cycles++;
      @(posedge clk_i);
    end
    if (row.typed) begin
      for (int i = 0; i < row.n_typed; i++) begin
        w.audio_sample = ZERO_S;
        w.clipped = 1'b0;
        w.stream_end = row.fin && (i == row.n_typed - 1);
        expected_words.push_back(w);
      end
    end
    synth_frame(row, !row.typed);
    frames_sent++;
    if (row.fin) begin
      streams_sent++;
    end
  endtask

  function automatic void check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected output word: audio_sample %0d clipped %0b stream_end %0b",
             audio_sample_o, clipped_o, stream_end_o);
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (want.clipped) begin
      words_clipped++;
    end
    if (want.stream_end) begin
      stream_ends++;
    end
    if (audio_sample_o !== want.audio_sample) begin
      $error("audio_sample: expected %0d, got %0d", want.audio_sample, audio_sample_o);
      mismatches++;
    end
    if (clipped_o !== want.clipped) begin
      $error("clipped: expected %0b, got %0b", want.clipped, clipped_o);
      mismatches++;
    end
    if (stream_end_o !== want.stream_end) begin
      $error("stream_end: expected %0b, got %0b", want.stream_end, stream_end_o);
      mismatches++;
    end
  endfunction

  // Output side: random pops, plus one long hold-off to back up the input.
  initial begin : drain_words
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && words_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = pick_gap(rx_calm);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      check_word();
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin : run_stimulus
    frame_row_t row;
    int len;
    int r;
    build_synth_taps();
    clear_history();
    //           b0      b1      b2      b3      fin   typed n
    dir_rows = '{
      '{ZERO_S, ZERO_S, ZERO_S, ZERO_S, 1'b1, 1'b1, 6'd4},  // lone final after reset
      '{ZERO_S, ZERO_S, ZERO_S, ZERO_S, 1'b0, 1'b1, 6'd0},  // stream start, nothing due
      '{ZERO_S, ZERO_S, ZERO_S, ZERO_S, 1'b0, 1'b1, 6'd0},
      '{POS_FS, POS_FS, POS_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, NEG_FS, NEG_FS, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, NEG_FS, POS_FS, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, POS_FS, NEG_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, ZERO_S, ZERO_S, ZERO_S, 1'b0, 1'b0, 6'd0},
      '{ZERO_S, POS_FS, ZERO_S, ZERO_S, 1'b0, 1'b0, 6'd0},  // first word of the stream
      '{ZERO_S, ZERO_S, POS_FS, ZERO_S, 1'b0, 1'b0, 6'd0},
      '{ZERO_S, ZERO_S, ZERO_S, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, POS_FS, NEG_FS, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, NEG_FS, POS_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, NEG_FS, NEG_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, POS_FS, POS_FS, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, POS_FS, POS_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{POS_FS, POS_FS, POS_FS, POS_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, NEG_FS, NEG_FS, NEG_FS, 1'b0, 1'b0, 6'd0},  // frame count saturates
      '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b1, 1'b0, 6'd0}, // capped flush
      '{POS_FS, NEG_FS, POS_FS, NEG_FS, 1'b0, 1'b0, 6'd0},
      '{NEG_FS, POS_FS, NEG_FS, POS_FS, 1'b1, 1'b0, 6'd0},  // two-frame stream
      '{16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 1'b1, 1'b0, 6'd0},
      '{ZERO_S, ZERO_S, ZERO_S, ZERO_S, 1'b1, 1'b1, 6'd4}   // history cleared by flush
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_frame(dir_rows[i]);
    end

    // Random streams, each closed by a final frame; mostly of eight frames or more.
    while (frames_sent < ITEMS) begin
      r = $urandom_range(99);
      if (r < 15) begin
        len = $urandom_range(7, 1);
      end else if (r < 90) begin
        len = $urandom_range(24, 8);
      end else begin
        len = $urandom_range(45, 25);
      end
      if (len > ITEMS - frames_sent) begin
        len = ITEMS - frames_sent;
      end
      for (int i = 0; i < len; i++) begin
        row.b0 = random_sample();
        row.b1 = random_sample();
        row.b2 = random_sample();
        row.b3 = random_sample();
        row.fin = (i == len - 1);
        row.typed = 1'b0;
        row.n_typed = '0;
        send_frame(row);
      end
    end
    push <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames in %0d streams; checked %0d output words, %0d clipped, %0d ends.",
             frames_sent, streams_sent, words_checked, words_clipped, stream_ends);
    $display("Input held off by a full block for %0d cycles.", full_cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
design/pqmf_pkg.sv
design/pqmf_front.sv
design/pqmf_job_queue.sv
design/pqmf_back.sv
design/pqmf_result_queue.sv
design/pqmf_synthesis_filterbank_unit.sv
tb/sv/tb_pqmf_synthesis_filterbank_unit.sv
